// ----- src/dpbp_pkg.sv -----
package dpbp_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_MIN_DEPTH = 3'd4,
    REG_MAX_DEPTH = 3'd5
  } cfg_reg_t;

  localparam int POS_W   = 10;
  localparam int OFF_W   = 15;  // |pos*16 - centre| for 10-bit pos, 14-bit centre
  localparam int DEN_W   = 16;
  localparam int QUO_W   = 24;  // enough to detect saturation
  localparam logic [15:0] FOCAL_MIN = 16'd16;

  // word carried down the cell row for one axis
  typedef struct packed {
    logic [OFF_W+16-1:0] rem;   // partial remainder / numerator bits
    logic [QUO_W-1:0]    quo;   // quotient bits developed so far
    logic [DEN_W-1:0]    den;
    logic                neg;
    logic                sat;   // quotient already known too large
  } div_word_t;

  typedef struct packed {
    logic        keep;
    logic [15:0] z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } side_t;

endpackage

// ----- src/dpbp_cell.sv -----
// One restoring-division step: quotient bit at position BIT.
module dpbp_cell #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                en,
  input  dpbp_pkg::div_word_t word_i,
  output dpbp_pkg::div_word_t word_o
);
  localparam int RW = dpbp_pkg::OFF_W + 16;

  logic [RW+dpbp_pkg::QUO_W-1:0] den_sh;
  logic                          fits;
  dpbp_pkg::div_word_t           word_nxt, word_r;

  assign den_sh = {{(RW+dpbp_pkg::QUO_W-dpbp_pkg::DEN_W){1'b0}}, word_i.den} << BIT;
  assign fits   = den_sh <= {{dpbp_pkg::QUO_W{1'b0}}, word_i.rem};

  always_comb begin
    word_nxt = word_i;
    if (fits) begin
      word_nxt.rem      = word_i.rem - den_sh[RW-1:0];
      word_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign word_o = word_r;
endmodule

// ----- src/dpbp_axis.sv -----
// One axis: multiply stage, then a row of divider cells, then saturation.
module dpbp_axis (
  input  logic                        clk,
  input  logic                        en,
  input  logic [dpbp_pkg::POS_W-1:0]  pos,
  input  logic [13:0]                 centre,
  input  logic [15:0]                 depth,
  input  logic [15:0]                 focal,
  output logic [dpbp_pkg::QUO_W-1:0]  coord
);
  localparam int POS_W = dpbp_pkg::POS_W;
  localparam int QW = dpbp_pkg::QUO_W;
  localparam int RW = dpbp_pkg::OFF_W + 16;

  logic signed [POS_W+5:0]  off;
  logic [POS_W+4:0]         mag;
  dpbp_pkg::div_word_t      chain [QW+1];
  dpbp_pkg::div_word_t      head_r;

  assign off = $signed({2'b00, pos, 4'b0000}) - $signed({{(POS_W-8){1'b0}}, centre});
  assign mag = off[POS_W+5] ? (POS_W+5)'(-off) : (POS_W+5)'(off);

  always_ff @(posedge clk) begin
    if (en) begin
      head_r.rem <= RW'(mag) * RW'(depth);
      head_r.quo <= '0;
      head_r.den <= (focal < dpbp_pkg::FOCAL_MIN) ? dpbp_pkg::FOCAL_MIN : focal;
      head_r.neg <= off[POS_W+5];
      head_r.sat <= 1'b0;
    end
  end

  assign chain[0] = head_r;

  // one cell per quotient bit, MSB first; overflow beyond the quotient width is flagged below
  for (genvar i = 0; i < QW; i++) begin : g_cell
    dpbp_cell #(.BIT(QW-1-i)) u_cell (
      .clk(clk), .en(en), .word_i(chain[i]), .word_o(chain[i+1])
    );
  end

  logic [RW+QW-1:0] ovf_lim;
  logic             ovf;
  assign ovf_lim = {{(RW+QW-dpbp_pkg::DEN_W){1'b0}}, head_r.den} << QW;
  assign ovf     = {{QW{1'b0}}, head_r.rem} >= ovf_lim;

  // carry overflow flag alongside the row
  logic [QW-1:0] sat_line_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sat_line_r <= {sat_line_r[QW-2:0], ovf};
    end
  end

  logic [QW-1:0] q;
  logic          big;
  assign q   = chain[QW].quo;
  assign big = sat_line_r[QW-1];

  always_comb begin
    priority if (chain[QW].neg) begin
      if (big || q > 24'd8388608) coord = 24'h800000;
      else                        coord = QW'(-q);
    end else begin
      if (big || q > 24'd8388607) coord = 24'h7FFFFF;
      else                        coord = q;
    end
  end
endmodule

// ----- src/depth_pixel_backprojection.sv -----
// Channel | Direction | Payload
// in_     | slave     | tdata {blue,green,red,depth_raw,pixel_row,pixel_col}, tlast last_pixel
// out_    | master    | tdata {blue,green,red,point_z,point_y,point_x}, tuser keep_point,
//         |           | tlast frame_end
// cfg_    | write     | register index / data
// One word per clock sustained while the output is not stalled; 26 register stages (multiply
// stage, 24 divider cells, output register), set by the 24-cell quotient row per axis.
// The whole pipeline advances together; out_tready low while out_tvalid is high freezes every stage.
// Synchronous active-low reset clears valid bits and loads register defaults.
module depth_pixel_backprojection #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pixel_col, pixel_row, depth_raw, red, green, blue
  input  logic        in_tlast,   // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // point_x, point_y, point_z, red, green, blue
  output logic        out_tuser,  // keep_point
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int DEPTH = dpbp_pkg::QUO_W + 2;

  logic [15:0] focal_x_r, focal_y_r, min_depth_r, max_depth_r;
  logic [13:0] center_x_r, center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= 16'd8400; focal_y_r <= 16'd8400;
      center_x_r <= 14'd5112; center_y_r <= 14'd3832;
      min_depth_r <= 16'd0; max_depth_r <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpbp_pkg::REG_FOCAL_X:   focal_x_r   <= cfg_data;
        dpbp_pkg::REG_FOCAL_Y:   focal_y_r   <= cfg_data;
        dpbp_pkg::REG_CENTER_X:  center_x_r  <= cfg_data[13:0];
        dpbp_pkg::REG_CENTER_Y:  center_y_r  <= cfg_data[13:0];
        dpbp_pkg::REG_MIN_DEPTH: min_depth_r <= cfg_data;
        dpbp_pkg::REG_MAX_DEPTH: max_depth_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall-all pipeline; output stage acts as the skid point
  logic en;
  logic [DEPTH-1:0] vld_r;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  logic [9:0]  col, row;
  logic [15:0] d;
  assign col = in_tdata[9:0];
  assign row = in_tdata[19:10];
  assign d   = in_tdata[35:20];

  dpbp_pkg::side_t side_in, side_line_r [DEPTH-1];
  assign side_in.keep  = (d > min_depth_r) && (d < max_depth_r) &&
                         ({22'd0, col} < 32'(MAX_COLS)) && ({22'd0, row} < 32'(MAX_ROWS));
  assign side_in.z     = d;
  assign side_in.red   = in_tdata[43:36];
  assign side_in.green = in_tdata[51:44];
  assign side_in.blue  = in_tdata[59:52];
  assign side_in.last  = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_line_r[0] <= side_in;
      for (int i = 1; i < DEPTH-1; i++) side_line_r[i] <= side_line_r[i-1];
    end
  end

  logic [23:0] px, py;
  dpbp_axis u_x (
    .clk(clk), .en(en), .pos(col), .centre(center_x_r), .depth(d),
    .focal(focal_x_r), .coord(px)
  );
  dpbp_axis u_y (
    .clk(clk), .en(en), .pos(row), .centre(center_y_r), .depth(d),
    .focal(focal_y_r), .coord(py)
  );

  dpbp_pkg::side_t s_last;
  logic [87:0]  out_data_r;
  logic         out_keep_r, out_last_r;
  assign s_last = side_line_r[DEPTH-2];

  always_ff @(posedge clk) begin
    if (en) begin
      out_keep_r <= s_last.keep;
      out_last_r <= s_last.last;
      out_data_r <= s_last.keep ? {s_last.blue, s_last.green, s_last.red, s_last.z, py, px}
                                : 88'd0;
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_keep_r;
  assign out_tlast  = out_last_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("pipeline blocked while empty");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 88'd0) else $error("rejected point not zero");
endmodule
